// ===== src/aip_pkg.sv =====
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types, character codes and digit helpers for the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int OUT_WIDTH       = 32;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SIGN,
        PH_ZERO,
        PH_DIGS
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_HEX,
        RADIX_BIN,
        RADIX_OCT
    } radix_t;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CASE_FOLD  = 8'h20;
    localparam logic [7:0] DIGIT_GAP  = 8'd17;
    localparam logic [7:0] ALPHA_SKIP = 8'd7;
    localparam logic [7:0] DEC_TOP    = 8'd9;

    typedef struct packed {
        logic       ok;
        logic [4:0] val;
    } digit_t;

    typedef struct packed {
        logic                 fire;
        logic                 ok;
        logic [7:0]           end_char;
        logic [OUT_WIDTH-1:0] value;
    } result_t;

    function automatic logic [7:0] radix_value(radix_t rc);
        logic [7:0] r;
        case (rc)
            RADIX_HEX: r = 8'd16;
            RADIX_BIN: r = 8'd2;
            RADIX_OCT: r = 8'd8;
            default:   r = 8'd10;
        endcase
        return r;
    endfunction

    function automatic logic is_term(logic [7:0] ch);
        return (ch <= CH_SPACE) || (ch == CH_DOT);
    endfunction

    function automatic logic is_dec(logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    // byte arithmetic mapping: ':' to '@' land on 10 to 16
    function automatic digit_t map_digit(logic [7:0] ch, radix_t rc);
        logic [7:0] d;
        digit_t     res;
        d      = ch;
        res.ok = 1'b1;
        if (d >= CH_LOWER_A)
        begin
            d = d - CASE_FOLD;
        end
        d = d - CH_ZERO;
        if (d >= DIGIT_GAP)
        begin
            d = d - ALPHA_SKIP;
            if (d <= DEC_TOP)
            begin
                res.ok = 1'b0;
            end
        end
        if (d >= radix_value(rc))
        begin
            res.ok = 1'b0;
        end
        res.val = d[4:0];
        return res;
    endfunction

endpackage

// ===== src/aip_step.sv =====
// ----------------------------------------------------------------------------
// aip_step
// One parser step: classifies a byte, updates the parse state and forms the
// result beat when the number ends or the byte is rejected.
// ----------------------------------------------------------------------------
module aip_step #(
    parameter int VALUE_WIDTH = aip_pkg::VALUE_WIDTH_DEF
) (
    input  logic [7:0]             ch,
    input  aip_pkg::phase_t        phase,
    input  aip_pkg::radix_t        radix,
    input  logic                   negative,
    input  logic [VALUE_WIDTH-1:0] accum,
    output aip_pkg::phase_t        phase_next,
    output aip_pkg::radix_t        radix_next,
    output logic                   negative_next,
    output logic [VALUE_WIDTH-1:0] accum_next,
    output aip_pkg::result_t       result
);

    localparam int CW = (VALUE_WIDTH < aip_pkg::OUT_WIDTH) ? VALUE_WIDTH : aip_pkg::OUT_WIDTH;

    aip_pkg::radix_t        radix_use;
    aip_pkg::digit_t        dig;
    logic [VALUE_WIDTH-1:0] scaled;
    logic [VALUE_WIDTH-1:0] acc_mac;
    logic [VALUE_WIDTH-1:0] signed_acc;
    logic [aip_pkg::OUT_WIDTH-1:0] acc_out;

    // radix that applies to a digit in this phase
    always_comb
    begin
        case (phase)
            aip_pkg::PH_ZERO: radix_use = aip_pkg::RADIX_OCT;
            aip_pkg::PH_DIGS: radix_use = radix;
            default:          radix_use = aip_pkg::RADIX_DEC;
        endcase
    end

    assign dig = aip_pkg::map_digit(ch, radix_use);

    always_comb
    begin
        case (radix_use)
            aip_pkg::RADIX_HEX: scaled = accum << 4;
            aip_pkg::RADIX_BIN: scaled = accum << 1;
            aip_pkg::RADIX_OCT: scaled = accum << 3;
            default:            scaled = (accum << 3) + (accum << 1);
        endcase
    end

    assign acc_mac    = scaled + VALUE_WIDTH'(dig.val);
    assign signed_acc = negative ? (VALUE_WIDTH'(0) - accum) : accum;
    assign acc_out    = aip_pkg::OUT_WIDTH'(signed_acc[CW-1:0]);

    always_comb
    begin
        phase_next      = phase;
        radix_next      = radix;
        negative_next   = negative;
        accum_next      = accum;
        result.fire     = 1'b0;
        result.ok       = 1'b0;
        result.end_char = ch;
        result.value    = '0;

        case (phase)
            aip_pkg::PH_IDLE, aip_pkg::PH_SIGN:
            begin
                if (phase == aip_pkg::PH_IDLE && ch == aip_pkg::CH_SPACE)
                begin
                    phase_next = phase;
                end
                else if (phase == aip_pkg::PH_IDLE && ch == aip_pkg::CH_MINUS)
                begin
                    negative_next = 1'b1;
                    phase_next    = aip_pkg::PH_SIGN;
                end
                else if (ch == aip_pkg::CH_ZERO)
                begin
                    phase_next = aip_pkg::PH_ZERO;
                end
                else if (!aip_pkg::is_dec(ch))
                begin
                    result.fire = 1'b1;
                end
                else
                begin
                    radix_next = aip_pkg::RADIX_DEC;
                    accum_next = acc_mac;
                    phase_next = aip_pkg::PH_DIGS;
                end
            end
            aip_pkg::PH_ZERO:
            begin
                accum_next = '0;
                if (ch == aip_pkg::CH_X)
                begin
                    radix_next = aip_pkg::RADIX_HEX;
                    phase_next = aip_pkg::PH_DIGS;
                end
                else if (ch == aip_pkg::CH_B)
                begin
                    radix_next = aip_pkg::RADIX_BIN;
                    phase_next = aip_pkg::PH_DIGS;
                end
                else if (aip_pkg::is_term(ch))
                begin
                    result.fire = 1'b1;
                    result.ok   = 1'b1;
                end
                else if (!aip_pkg::is_dec(ch) || !dig.ok)
                begin
                    result.fire = 1'b1;
                end
                else
                begin
                    radix_next = aip_pkg::RADIX_OCT;
                    accum_next = acc_mac;
                    phase_next = aip_pkg::PH_DIGS;
                end
            end
            default:
            begin
                if (aip_pkg::is_term(ch))
                begin
                    result.fire  = 1'b1;
                    result.ok    = 1'b1;
                    result.value = acc_out;
                end
                else if (!dig.ok)
                begin
                    result.fire = 1'b1;
                end
                else
                begin
                    accum_next = acc_mac;
                end
            end
        endcase

        // every result restarts the parse
        if (result.fire)
        begin
            phase_next    = aip_pkg::PH_IDLE;
            radix_next    = aip_pkg::RADIX_DEC;
            negative_next = 1'b0;
            accum_next    = '0;
        end
    end

endmodule

// ===== src/ascii_integer_parser_core.sv =====
// ----------------------------------------------------------------------------
// ascii_integer_parser_core
// Streaming ASCII to integer parser with optional sign and 0x / 0b / 0 radix
// prefix; one character beat in, at most one result beat out.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------
//  char     | char_valid / char_ready    | char_in[7:0]
//  result   | result_valid / result_ready| value[31:0], ok, end_char[7:0]
//
//  one character beat per cycle while the result channel does not stall; a result
//  beat's terminating byte is taken into the input register, and the result
//  register is loaded when that byte moves forward
//  the parse state advances only when the input register moves forward
//  a stalled result holds the input register, which then stalls char_ready
//  rst_n clears the parse state and both valid flags asynchronously
// ----------------------------------------------------------------------------
module ascii_integer_parser_core #(
    parameter int VALUE_WIDTH = aip_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                char_valid,
    output logic                                char_ready,
    input  logic [7:0]                          char_in,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [aip_pkg::OUT_WIDTH-1:0] value,
    output logic                                ok,
    output logic [7:0]                          end_char
);

    logic                   char_valid_reg;
    logic                   char_valid_next;
    logic [7:0]             char_reg;
    aip_pkg::phase_t        phase_reg;
    aip_pkg::phase_t        phase_next;
    aip_pkg::radix_t        radix_reg;
    aip_pkg::radix_t        radix_next;
    logic                   negative_reg;
    logic                   negative_next;
    logic [VALUE_WIDTH-1:0] accum_reg;
    logic [VALUE_WIDTH-1:0] accum_next;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    aip_pkg::result_t       step_result;
    logic [aip_pkg::OUT_WIDTH-1:0] value_reg;
    logic                   ok_reg;
    logic [7:0]             end_char_reg;
    logic                   advance;

    assign advance    = char_valid_reg && (!result_valid_reg || result_ready);
    assign char_ready = !char_valid_reg || advance;

    aip_step #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step (
        .ch            (char_reg),
        .phase         (phase_reg),
        .radix         (radix_reg),
        .negative      (negative_reg),
        .accum         (accum_reg),
        .phase_next    (phase_next),
        .radix_next    (radix_next),
        .negative_next (negative_next),
        .accum_next    (accum_next),
        .result        (step_result)
    );

    always_comb
    begin
        char_valid_next = char_ready ? char_valid : char_valid_reg;
        if (advance && step_result.fire)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            phase_reg        <= aip_pkg::PH_IDLE;
            radix_reg        <= aip_pkg::RADIX_DEC;
            negative_reg     <= 1'b0;
            accum_reg        <= '0;
        end
        else
        begin
            char_valid_reg   <= char_valid_next;
            result_valid_reg <= result_valid_next;
            if (advance)
            begin
                phase_reg    <= phase_next;
                radix_reg    <= radix_next;
                negative_reg <= negative_next;
                accum_reg    <= accum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            char_reg <= char_in;
        end
        if (advance && step_result.fire)
        begin
            value_reg    <= step_result.value;
            ok_reg       <= step_result.ok;
            end_char_reg <= step_result.end_char;
        end
    end

    assign result_valid = result_valid_reg;
    assign value        = value_reg;
    assign ok           = ok_reg;
    assign end_char     = end_char_reg;

endmodule

// ===== src/aip_checker.sv =====
// ----------------------------------------------------------------------------
// aip_checker
// Port-level checks for the ASCII integer parser, bound to the top level.
// ----------------------------------------------------------------------------
module aip_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 result_valid,
    input logic                                 result_ready,
    input logic signed [aip_pkg::OUT_WIDTH-1:0] value,
    input logic                                 ok,
    input logic [7:0]                           end_char
);

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(value) && $stable(ok) && $stable(end_char))
        else $error("result beat changed while stalled");

    // failed parse reports zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !ok |-> value == '0)
        else $error("failed parse with non-zero value");

    // a good number always ends on a terminator
    a_ok_term: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ok |-> (end_char <= aip_pkg::CH_SPACE) || (end_char == aip_pkg::CH_DOT))
        else $error("good result without terminator byte");

    // nothing pending straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result beat present right after reset");

endmodule

bind ascii_integer_parser_core aip_checker u_aip_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .value        (value),
    .ok           (ok),
    .end_char     (end_char)
);
